// File: rtl/olt_pkg.sv
`default_nettype none

package olt_pkg;

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // cells examined per scan cycle
    localparam int LANE = 8;

    typedef logic [OPCODE_W-1:0]        opcode_t;
    typedef logic signed [VALUE_W-1:0]  value_t;
    typedef logic [STATUS_W-1:0]        status_t;
    typedef logic [COUNT_W-1:0]         count_t;

    localparam opcode_t OP_HEAD   = 2'd0;
    localparam opcode_t OP_TAIL   = 2'd1;
    localparam opcode_t OP_SORTED = 2'd2;
    localparam opcode_t OP_REMOVE = 2'd3;

    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic compare;
        logic scan;
        logic update;
        logic result;
    } olt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic reject;
        logic search;
        logic remove;
        logic hit;
        logic scan_last;
        logic out_busy;
    } olt_stat_t;

endpackage

`default_nettype wire

// File: rtl/olt_if.sv
`default_nettype none

interface olt_req_if;
    logic             valid;
    logic             ready;
    olt_pkg::opcode_t opcode;
    olt_pkg::value_t  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface olt_resp_if;
    logic             valid;
    logic             ready;
    olt_pkg::status_t status;
    olt_pkg::count_t  count;

    modport source (output valid, output status, output count, input ready);
    modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/olt_ctrl.sv
`default_nettype none

module olt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  olt_pkg::olt_stat_t stat,
    output olt_pkg::olt_cmd_t  cmd
);
    import olt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        req_ready  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                if (stat.reject)
                    state_next = S_DONE;
                else if (stat.search)
                    state_next = S_SCAN;
                else
                    state_next = S_UPD;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.hit)
                    state_next = S_UPD;
                else if (stat.scan_last)
                    state_next = stat.remove ? S_DONE : S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.result = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: rtl/olt_dp.sv
`default_nettype none

module olt_dp #(
    parameter int CAPACITY = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  olt_pkg::opcode_t   opcode,
    input  olt_pkg::value_t    value,
    input  olt_pkg::olt_cmd_t  cmd,
    output olt_pkg::olt_stat_t stat,
    input  logic               resp_ready,
    output logic               resp_valid,
    output olt_pkg::status_t   status,
    output olt_pkg::count_t    count
);
    import olt_pkg::*;

    localparam int FW        = $clog2(CAPACITY + 1);
    localparam int LW        = $clog2(LANE);
    localparam int GROUPS    = (CAPACITY + LANE - 1) / LANE;
    localparam int SCAN_BITS = GROUPS * LANE;
    localparam int GW        = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int NW        = GW + 1 + LW;

    value_t                cell_reg [CAPACITY];
    opcode_t               op_reg;
    value_t                val_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         pos_reg;
    logic [GW-1:0]         grp_reg;
    logic [SCAN_BITS-1:0]  flag_reg;
    status_t               status_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    count_t                out_count_reg;

    logic [CAPACITY-1:0]   cell_match;
    logic [LANE-1:0]       grp_bits;
    logic [LW-1:0]         first_idx;
    logic [GW:0]           grp_inc;
    logic [FW-1:0]         hit_pos;
    logic                  is_remove;

    assign is_remove = (op_reg == OP_REMOVE);

    // per-cell compare against the captured value, then shift on update
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        value_t prev_cell;
        value_t next_cell;
        logic   cell_lt;

        if (i == 0)
        begin : g_first
            assign prev_cell = val_reg;
        end
        else
        begin : g_mid_prev
            assign prev_cell = cell_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_cell = cell_reg[i];
        end
        else
        begin : g_mid_next
            assign next_cell = cell_reg[i+1];
        end

        assign cell_lt       = (cell_reg[i] < val_reg);
        assign cell_match[i] = (FW'(i) < fill_reg)
                             && (is_remove ? (cell_reg[i] == val_reg) : !cell_lt);

        always_ff @(posedge clk)
        begin
            if (cmd.update)
            begin
                if (is_remove)
                begin
                    if (FW'(i) >= pos_reg)
                        cell_reg[i] <= next_cell;
                end
                else if (FW'(i) == pos_reg)
                    cell_reg[i] <= val_reg;
                else if (FW'(i) > pos_reg)
                    cell_reg[i] <= prev_cell;
            end
        end
    end

    // one group of match flags per scan cycle
    assign grp_bits = flag_reg[{grp_reg, {LW{1'b0}}} +: LANE];

    always_comb
    begin
        first_idx = '0;
        for (int k = LANE - 1; k >= 0; k--)
        begin
            if (grp_bits[k])
                first_idx = LW'(k);
        end
    end

    assign grp_inc = {1'b0, grp_reg} + (GW+1)'(1);
    assign hit_pos = FW'({grp_reg, first_idx});

    assign stat.reject    = !is_remove && (fill_reg == FW'(CAPACITY));
    assign stat.search    = (op_reg == OP_SORTED) || is_remove;
    assign stat.remove    = is_remove;
    assign stat.hit       = |grp_bits;
    assign stat.scan_last = ({grp_inc, {LW{1'b0}}} >= NW'(fill_reg));
    assign stat.out_busy  = out_valid_reg && !resp_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= opcode;
            val_reg <= value;
            grp_reg <= '0;
            pos_reg <= (opcode == OP_HEAD) ? '0 : fill_reg;
        end
        if (cmd.compare)
        begin
            flag_reg   <= SCAN_BITS'(cell_match);
            status_reg <= stat.reject ? ST_FULL : ST_DONE;
        end
        if (cmd.scan)
        begin
            grp_reg <= grp_inc[GW-1:0];
            if (stat.hit)
                pos_reg <= hit_pos;
            else if (stat.scan_last && is_remove)
                status_reg <= ST_NOT_FOUND;
        end
        if (cmd.result)
        begin
            out_status_reg <= status_reg;
            out_count_reg  <= COUNT_W'(fill_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.update)
                fill_reg <= is_remove ? fill_reg - FW'(1) : fill_reg + FW'(1);
            if (cmd.result)
                out_valid_reg <= 1'b1;
            else if (resp_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign resp_valid = out_valid_reg;
    assign status     = out_status_reg;
    assign count      = out_count_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(CAPACITY))
        else $error("fill exceeds capacity");

    a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && is_remove |-> fill_reg != '0)
        else $error("remove applied to empty store");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && !is_remove |=> fill_reg == $past(fill_reg) + FW'(1))
        else $error("insert did not grow fill by one");

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result |-> !out_valid_reg || resp_ready)
        else $error("result written over a pending beat");
`endif

endmodule

`default_nettype wire

// File: rtl/ordered_list_table_top.sv
// ordered list table: a bounded sequence of signed 32-bit values kept in a row of cells
// request channel (sink): one beat carries an opcode and a value
//   head insert, tail insert, sorted insert (before the first entry not less than value),
//   or remove of the first entry equal to value
// response channel (source): one beat per request with a status and the new count
//   status is done, not found (remove) or full (any insert into a full store)
// one request is worked at a time; the request side is ready only while idle
// each request passes load, compare, an optional scan, update and response write in turn;
//   refused inserts skip the update, sorted insert and remove scan the match flags, and
//   a remove that misses its value skips the update after the scan; the scan checks
//   eight cells per cycle and ends at the first group with a match or at the group that
//   holds the last entry, and a new request is taken only after the response is written
// the response sits in an output register, so a stalled receiver only holds the
//   controller once the next result is ready to be written
// reset clears the count and the control state; cell contents stay undefined and
//   only cells below the count are ever read
// CAPACITY sets the number of cells (2 to 256); count is reported masked to five bits

`default_nettype none

module ordered_list_table_top #(
    parameter int CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    olt_req_if.sink     request,
    olt_resp_if.source  response
);
    import olt_pkg::*;

    olt_cmd_t  cmd;
    olt_stat_t stat;

    // sequencing of compare, scan, update and response write
    olt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // cell row, match flags, fill count and response register
    olt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .opcode     (request.opcode),
        .value      (request.value),
        .cmd        (cmd),
        .stat       (stat),
        .resp_ready (response.ready),
        .resp_valid (response.valid),
        .status     (response.status),
        .count      (response.count)
    );

endmodule

`default_nettype wire
